// File: rtl/memory_request_sequencer_defines.svh
// assertion macros shared by the memory request sequencer rtl
// no dependencies; every macro samples on clk and is disabled while rst is high
`ifndef MEMORY_REQUEST_SEQUENCER_DEFINES_SVH
`define MEMORY_REQUEST_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define MSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MSQ_ASSERT_NOW(lbl, ante, cons, msg)
`define MSQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/msq_pkg.sv
// shared constants and beat types of the memory request sequencer
// no dependencies
`timescale 1ns / 1ps

package msq_pkg;

  // delay line depths, 1..16
  localparam int CONTROL_DELAY  = 2;
  localparam int RESPONSE_DELAY = 3;
  // internal data and address widths, 8..64
  localparam int DATA_BITS      = 64;
  localparam int ADDRESS_BITS   = 32;

  // port widths
  localparam int WORD_W = 64;
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;

  // write strobe carried by every write request (always full)
  localparam logic [15:0] FULL_STROBE = 16'hffff;

  typedef struct packed {
    logic              read_enable;
    logic              read_final;
    logic              write_enable;
    logic              write_final;
    logic              last_instruction;
    logic              scheduler_in_data_out;
    logic [ADDR_W-1:0] req_address;
    logic [WORD_W-1:0] req_write_data;
    logic              response_valid;
    logic [WORD_W-1:0] response_word;
  } item_t;

  typedef struct packed {
    logic              mem_request_valid;
    logic              mem_request_write;
    logic [ADDR_W-1:0] mem_request_address;
    logic [WORD_W-1:0] mem_request_data;
    logic [WORD_W-1:0] read_word;
    logic              read_word_valid;
    logic              read_word_final;
    logic              final_write_done;
    logic [1:0]        controller_state;
    logic [CNT_W-1:0]  early_response_count;
    logic [CNT_W-1:0]  missing_response_count;
  } result_t;

  // config write strobe and data into the core
  typedef struct packed {
    logic we;
    logic strict_timing;
  } cfg_t;

endpackage

// File: rtl/memory_request_sequencer.sv
// memory request sequencer: one beat in is one clock of the memory interface
// the result beat carries the request, delayed read data and response counters
// uses: register stage and the output buffer
//   item channel (item_valid / item_stall): request fields plus the memory
//   response seen in that clock. a beat is taken when valid is high and stall
//   is low.
//   result channel (result_valid / result_stall): one result beat per item
//   beat, in order, showing every register as it stands after that item.
//   config channel (cfg_valid / cfg_ready / cfg_data): writes strict_timing,
//   which enables counting of early and missing responses. ready is always
//   high; write only while no beat is in flight.
//   latency: a result is valid the cycle after its item if output is free.
//   throughput: one item per cycle while item_stall is low; all work for a
//   beat is a single register stage, and the output register plus a one-entry
//   skid stage keep taking items while a result waits.
//   stall: with the receiver stalled, one more item is taken into the skid
//   stage, then item_stall rises until the receiver takes a beat.
//   reset (rst, synchronous): clears core registers and buffer valid flags,
//   controller idle, strict_timing 1; no result beat is pending after reset.
`timescale 1ns / 1ps

module memory_request_sequencer import msq_pkg::*; (
  input  logic              clk,
  input  logic              rst,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,

  input  logic              item_valid,
  output logic              item_stall,
  input  logic              read_enable,
  input  logic              read_final,
  input  logic              write_enable,
  input  logic              write_final,
  input  logic              last_instruction,
  input  logic              scheduler_in_data_out,
  input  logic [ADDR_W-1:0] req_address,
  input  logic [WORD_W-1:0] req_write_data,
  input  logic              response_valid,
  input  logic [WORD_W-1:0] response_word,

  output logic              result_valid,
  input  logic              result_stall,
  output logic              mem_request_valid,
  output logic              mem_request_write,
  output logic [ADDR_W-1:0] mem_request_address,
  output logic [WORD_W-1:0] mem_request_data,
  output logic [WORD_W-1:0] read_word,
  output logic              read_word_valid,
  output logic              read_word_final,
  output logic              final_write_done,
  output logic [1:0]        controller_state,
  output logic [CNT_W-1:0]  early_response_count,
  output logic [CNT_W-1:0]  missing_response_count
);

  item_t   item;
  cfg_t    cfg;
  result_t core_result;
  result_t out_beat;
  logic    fire;
  logic    skid_full;

  assign cfg_ready         = 1'b1;
  assign cfg.we            = cfg_valid && cfg_ready;
  assign cfg.strict_timing = cfg_data;

  assign item_stall = skid_full;
  assign fire       = item_valid && !item_stall;

  assign item.read_enable           = read_enable;
  assign item.read_final            = read_final;
  assign item.write_enable          = write_enable;
  assign item.write_final           = write_final;
  assign item.last_instruction      = last_instruction;
  assign item.scheduler_in_data_out = scheduler_in_data_out;
  assign item.req_address           = req_address;
  assign item.req_write_data        = req_write_data;
  assign item.response_valid        = response_valid;
  assign item.response_word         = response_word;

  msq_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item),
    .result (core_result)
  );

  msq_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fire),
    .in_beat   (core_result),
    .full      (skid_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_beat  (out_beat)
  );

  assign mem_request_valid      = out_beat.mem_request_valid;
  assign mem_request_write      = out_beat.mem_request_write;
  assign mem_request_address    = out_beat.mem_request_address;
  assign mem_request_data       = out_beat.mem_request_data;
  assign read_word              = out_beat.read_word;
  assign read_word_valid        = out_beat.read_word_valid;
  assign read_word_final        = out_beat.read_word_final;
  assign final_write_done       = out_beat.final_write_done;
  assign controller_state       = out_beat.controller_state;
  assign early_response_count   = out_beat.early_response_count;
  assign missing_response_count = out_beat.missing_response_count;

endmodule

// File: rtl/msq_core.sv
// request register, delay lines, controller and response checking counters
// depends on msq_pkg and memory_request_sequencer_defines.svh
`timescale 1ns / 1ps
`include "memory_request_sequencer_defines.svh"

module msq_core import msq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_REQ  = 2'd1,
    ST_WAIT = 2'd2
  } state_t;

  logic strict_timing;

  logic [DATA_BITS-1:0]      response_hold, response_hold_next;
  logic [DATA_BITS-1:0]      read_data_reg, read_data_reg_next;
  logic [CONTROL_DELAY-1:0]  read_valid_line, read_valid_line_next;
  logic [CONTROL_DELAY-1:0]  read_last_line, read_last_line_next;
  logic [RESPONSE_DELAY-1:0] expected_line, expected_line_next;
  logic                      read_valid_reg, read_valid_reg_next;
  logic                      read_last_reg, read_last_reg_next;
  logic                      request_valid, request_valid_next;
  logic                      request_write, request_write_next;
  logic [ADDRESS_BITS-1:0]   request_address, request_address_next;
  logic [DATA_BITS-1:0]      request_data, request_data_next;
  logic                      write_done, write_done_next;
  state_t                    state, state_next;
  logic [CNT_W-1:0]          early_cnt, early_cnt_next;
  logic [CNT_W-1:0]          missing_cnt, missing_cnt_next;

  logic rd, wr, rd_last, wr_last, expected;
  logic [15:0] strobe;

  assign rd       = item.read_enable;
  assign wr       = item.write_enable;
  assign rd_last  = rd & item.read_final;
  assign wr_last  = wr & item.write_final;
  assign expected = expected_line[RESPONSE_DELAY-1];
  // reads carry no strobe, writes the full one
  assign strobe   = request_write_next ? FULL_STROBE : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_timing <= 1'b1;
    end else if (cfg.we) begin
      strict_timing <= cfg.strict_timing;
    end
  end

  always_comb begin
    // response counting looks at the expected line before it shifts
    early_cnt_next   = early_cnt;
    missing_cnt_next = missing_cnt;
    if (strict_timing) begin
      if (item.response_valid && !expected) begin
        if (early_cnt != '1) early_cnt_next = early_cnt + CNT_W'(1);
      end else if (!item.response_valid && expected) begin
        if (missing_cnt != '1) missing_cnt_next = missing_cnt + CNT_W'(1);
      end
    end

    read_data_reg_next = response_hold;
    response_hold_next = item.response_valid ? DATA_BITS'(item.response_word) : response_hold;

    read_valid_reg_next = read_valid_line[CONTROL_DELAY-1];
    read_last_reg_next  = read_last_line[CONTROL_DELAY-1];
    read_valid_line_next[0] = rd;
    read_last_line_next[0]  = rd_last;
    for (int i = 1; i < CONTROL_DELAY; i++) begin
      read_valid_line_next[i] = read_valid_line[i-1];
      read_last_line_next[i]  = read_last_line[i-1];
    end

    expected_line_next[0] = rd | wr;
    for (int i = 1; i < RESPONSE_DELAY; i++) begin
      expected_line_next[i] = expected_line[i-1];
    end

    // reads win over writes
    request_valid_next   = rd | wr;
    request_write_next   = !rd && wr;
    request_address_next = (rd | wr) ? ADDRESS_BITS'(item.req_address) : '0;
    request_data_next    = (!rd && wr) ? DATA_BITS'(item.req_write_data) : '0;
    write_done_next      = !rd && wr && item.write_final && item.last_instruction
                           && item.scheduler_in_data_out;

    state_next = state;
    if (rd || wr) begin
      unique case (state)
        ST_REQ:  state_next = ST_WAIT;
        ST_WAIT: if (rd_last || wr_last) state_next = ST_IDLE;
        default: state_next = ST_REQ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_hold   <= '0;
      read_data_reg   <= '0;
      read_valid_line <= '0;
      read_last_line  <= '0;
      expected_line   <= '0;
      read_valid_reg  <= 1'b0;
      read_last_reg   <= 1'b0;
      request_valid   <= 1'b0;
      request_write   <= 1'b0;
      request_address <= '0;
      request_data    <= '0;
      write_done      <= 1'b0;
      state           <= ST_IDLE;
      early_cnt       <= '0;
      missing_cnt     <= '0;
    end else if (fire) begin
      response_hold   <= response_hold_next;
      read_data_reg   <= read_data_reg_next;
      read_valid_line <= read_valid_line_next;
      read_last_line  <= read_last_line_next;
      expected_line   <= expected_line_next;
      read_valid_reg  <= read_valid_reg_next;
      read_last_reg   <= read_last_reg_next;
      request_valid   <= request_valid_next;
      request_write   <= request_write_next;
      request_address <= request_address_next;
      request_data    <= request_data_next;
      write_done      <= write_done_next;
      state           <= state_next;
      early_cnt       <= early_cnt_next;
      missing_cnt     <= missing_cnt_next;
    end
  end

  // result beat shows the registers as they stand after this beat
  always_comb begin
    result.mem_request_valid      = request_valid_next;
    result.mem_request_write      = strobe == FULL_STROBE;
    result.mem_request_address    = ADDR_W'(request_address_next);
    result.mem_request_data       = WORD_W'(request_data_next);
    result.read_word              = WORD_W'(read_data_reg_next);
    result.read_word_valid        = read_valid_reg_next;
    result.read_word_final        = read_last_reg_next;
    result.final_write_done       = write_done_next;
    result.controller_state       = state_next;
    result.early_response_count   = early_cnt_next;
    result.missing_response_count = missing_cnt_next;
  end

  `MSQ_ASSERT_NXT(a_cnt_hold, !fire || !strict_timing, $stable(early_cnt) && $stable(missing_cnt), "counters moved without a strict beat")
  `MSQ_ASSERT_NXT(a_early_inc, fire && strict_timing && item.response_valid && !expected && early_cnt != '1, early_cnt == $past(early_cnt) + CNT_W'(1), "early response not counted")
  `MSQ_ASSERT_NXT(a_cnt_excl, fire, !(early_cnt != $past(early_cnt) && missing_cnt != $past(missing_cnt)), "early and missing counted on one beat")
  `MSQ_ASSERT_NXT(a_idle_req, fire && (rd || wr) && state == ST_IDLE, state == ST_REQ, "idle controller did not move to requesting")

endmodule

// File: rtl/msq_skid.sv
// two-entry output buffer for result beats: output register plus skid stage
// depends on msq_pkg and memory_request_sequencer_defines.svh
`timescale 1ns / 1ps
`include "memory_request_sequencer_defines.svh"

module msq_skid import msq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_beat,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_beat
);

  logic    skid_valid;
  result_t skid_beat;
  logic    out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      // upstream is held off while the skid stage is full
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_beat <= skid_valid ? skid_beat : in_beat;
    end else if (in_valid) begin
      skid_beat <= in_beat;
    end
  end

  `MSQ_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid, "skid stage full with output empty")
  `MSQ_ASSERT_NXT(a_park, in_valid && out_valid && out_stall, skid_valid, "beat lost while output stalled")
  `MSQ_ASSERT_NXT(a_drain, skid_valid && !out_stall, !skid_valid && out_valid, "skid stage did not drain")

endmodule

// File: dv/memory_request_sequencer_tb.sv
// testbench for memory_request_sequencer: drives item beats over valid/stall and
// checks each result beat against a cycle-level shadow of the register stage
// depends on msq_pkg and rtl/memory_request_sequencer.sv
`timescale 1ns / 1ps

module memory_request_sequencer_tb;
  import msq_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 26;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;

  localparam logic [WORD_W-1:0] DATA_MASK =
    (DATA_BITS >= WORD_W) ? '1 : ((64'd1 << DATA_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? '1 : ((32'd1 << ADDRESS_BITS) - 32'd1);

  typedef enum logic [1:0] {
    CTRL_IDLE = 2'd0,
    CTRL_REQ  = 2'd1,
    CTRL_WAIT = 2'd2
  } ctrl_t;

  // shadow of the register stage plus the queue of result beats still due
  class request_stage_shadow;
    bit                strict_on;
    logic [WORD_W-1:0] resp_hold;
    logic [WORD_W-1:0] rd_data;
    bit                rv_line [CONTROL_DELAY];
    bit                rl_line [CONTROL_DELAY];
    bit                due_line[RESPONSE_DELAY];
    bit                rv_q;
    bit                rl_q;
    ctrl_t             ctrl;
    logic [CNT_W-1:0]  early_cnt;
    logic [CNT_W-1:0]  missing_cnt;
    result_t           results_due[$];
    int                mismatches;

    function new();
      strict_on   = 1'b1;
      resp_hold   = '0;
      rd_data     = '0;
      rv_q        = 1'b0;
      rl_q        = 1'b0;
      ctrl        = CTRL_IDLE;
      early_cnt   = '0;
      missing_cnt = '0;
      mismatches  = 0;
      foreach (rv_line[i]) begin
        rv_line[i] = 1'b0;
        rl_line[i] = 1'b0;
      end
      foreach (due_line[i]) due_line[i] = 1'b0;
    endfunction

    function void take_item(item_t it);
      result_t r;
      bit      rd;
      bit      wr;
      rd = it.read_enable;
      wr = it.write_enable;

      // counting looks at the oldest stage before the line shifts
      if (strict_on) begin
        if (it.response_valid && !due_line[RESPONSE_DELAY-1]) begin
          if (early_cnt != '1) early_cnt++;
        end else if (!it.response_valid && due_line[RESPONSE_DELAY-1]) begin
          if (missing_cnt != '1) missing_cnt++;
        end
      end

      rd_data = resp_hold;
      if (it.response_valid) resp_hold = it.response_word & DATA_MASK;

      rv_q = rv_line[CONTROL_DELAY-1];
      rl_q = rl_line[CONTROL_DELAY-1];
      for (int s = CONTROL_DELAY - 1; s > 0; s--) begin
        rv_line[s] = rv_line[s-1];
        rl_line[s] = rl_line[s-1];
      end
      rv_line[0] = rd;
      rl_line[0] = rd && it.read_final;

      for (int s = RESPONSE_DELAY - 1; s > 0; s--) due_line[s] = due_line[s-1];
      due_line[0] = rd || wr;

      r = '0;
      if (rd) begin
        r.mem_request_valid   = 1'b1;
        r.mem_request_address = it.req_address & ADDR_MASK;
      end else if (wr) begin
        r.mem_request_valid   = 1'b1;
        r.mem_request_write   = 1'b1;
        r.mem_request_address = it.req_address & ADDR_MASK;
        r.mem_request_data    = it.req_write_data & DATA_MASK;
        r.final_write_done    = it.write_final && it.last_instruction &&
                                it.scheduler_in_data_out;
      end

      if (rd || wr) begin
        case (ctrl)
          CTRL_REQ: ctrl = CTRL_WAIT;
          CTRL_WAIT: begin
            if ((rd && it.read_final) || (wr && it.write_final)) ctrl = CTRL_IDLE;
          end
          default: ctrl = CTRL_REQ;
        endcase
      end

      r.read_word              = rd_data;
      r.read_word_valid        = rv_q;
      r.read_word_final        = rl_q;
      r.controller_state       = ctrl;
      r.early_response_count   = early_cnt;
      r.missing_response_count = missing_cnt;
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      compare_field("mem_request_valid", want.mem_request_valid, got.mem_request_valid);
      compare_field("mem_request_write", want.mem_request_write, got.mem_request_write);
      compare_field("mem_request_address", want.mem_request_address,
                    got.mem_request_address);
      compare_field("mem_request_data", want.mem_request_data, got.mem_request_data);
      compare_field("read_word", want.read_word, got.read_word);
      compare_field("read_word_valid", want.read_word_valid, got.read_word_valid);
      compare_field("read_word_final", want.read_word_final, got.read_word_final);
      compare_field("final_write_done", want.final_write_done, got.final_write_done);
      compare_field("controller_state", want.controller_state, got.controller_state);
      compare_field("early_response_count", want.early_response_count,
                    got.early_response_count);
      compare_field("missing_response_count", want.missing_response_count,
                    got.missing_response_count);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;
  logic              item_valid;
  logic              item_stall;
  logic              read_enable;
  logic              read_final;
  logic              write_enable;
  logic              write_final;
  logic              last_instruction;
  logic              scheduler_in_data_out;
  logic [ADDR_W-1:0] req_address;
  logic [WORD_W-1:0] req_write_data;
  logic              response_valid;
  logic [WORD_W-1:0] response_word;
  logic              result_valid;
  logic              result_stall;
  logic              mem_request_valid;
  logic              mem_request_write;
  logic [ADDR_W-1:0] mem_request_address;
  logic [WORD_W-1:0] mem_request_data;
  logic [WORD_W-1:0] read_word;
  logic              read_word_valid;
  logic              read_word_final;
  logic              final_write_done;
  logic [1:0]        controller_state;
  logic [CNT_W-1:0]  early_response_count;
  logic [CNT_W-1:0]  missing_response_count;

  request_stage_shadow       shadow;
  bit                        sender_quiet;
  bit                        receiver_quiet;
  bit                        hold_request;
  bit [RESPONSE_DELAY-1:0]   req_history;
  int                        items_sent;
  int unsigned               cycles;

  memory_request_sequencer i_dut (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_data               (cfg_data),
    .item_valid             (item_valid),
    .item_stall             (item_stall),
    .read_enable            (read_enable),
    .read_final             (read_final),
    .write_enable           (write_enable),
    .write_final            (write_final),
    .last_instruction       (last_instruction),
    .scheduler_in_data_out  (scheduler_in_data_out),
    .req_address            (req_address),
    .req_write_data         (req_write_data),
    .response_valid         (response_valid),
    .response_word          (response_word),
    .result_valid           (result_valid),
    .result_stall           (result_stall),
    .mem_request_valid      (mem_request_valid),
    .mem_request_write      (mem_request_write),
    .mem_request_address    (mem_request_address),
    .mem_request_data       (mem_request_data),
    .read_word              (read_word),
    .read_word_valid        (read_word_valid),
    .read_word_final        (read_word_final),
    .final_write_done       (final_write_done),
    .controller_state       (controller_state),
    .early_response_count   (early_response_count),
    .missing_response_count (missing_response_count)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: sampled before this edge's updates land
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      shadow.match_result({mem_request_valid, mem_request_write, mem_request_address,
                           mem_request_data, read_word, read_word_valid,
                           read_word_final, final_write_done, controller_state,
                           early_response_count, missing_response_count});
  end

  initial begin : result_receiver
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= !receiver_quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.read_enable           = 1'($urandom_range(1));
    it.read_final            = 1'($urandom_range(1));
    it.write_enable          = 1'($urandom_range(1));
    it.write_final           = 1'($urandom_range(1));
    it.last_instruction      = 1'($urandom_range(1));
    it.scheduler_in_data_out = 1'($urandom_range(1));
    it.req_address           = ADDR_W'(rand_word());
    it.req_write_data        = rand_word();
    it.response_valid        = 1'($urandom_range(1));
    it.response_word         = rand_word();
    return it;
  endfunction

  // response lands when the memory would return it, now and then off time
  function automatic void time_response(inout item_t it);
    if ($urandom_range(99) < 85) it.response_valid = req_history[RESPONSE_DELAY-1];
    else it.response_valid = 1'($urandom_range(1));
  endfunction

  task automatic send_item(input item_t it);
    while (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid            <= 1'b1;
    read_enable           <= it.read_enable;
    read_final            <= it.read_final;
    write_enable          <= it.write_enable;
    write_final           <= it.write_final;
    last_instruction      <= it.last_instruction;
    scheduler_in_data_out <= it.scheduler_in_data_out;
    req_address           <= it.req_address;
    req_write_data        <= it.req_write_data;
    response_valid        <= it.response_valid;
    response_word         <= it.response_word;
    do @(posedge clk); while (item_stall);
    shadow.take_item(it);
    req_history = {req_history[RESPONSE_DELAY-2:0], it.read_enable | it.write_enable};
    items_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (shadow.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_strict(input bit value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.strict_on = value;
  endtask

  // one read or write burst closed by its final beat, then up to two empty beats
  task automatic send_burst();
    item_t it;
    int    len;
    bit    rd_burst;
    len      = $urandom_range(1, 6);
    rd_burst = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      it = random_item();
      it.read_enable  = rd_burst || ($urandom_range(9) == 0);
      it.write_enable = !rd_burst || ($urandom_range(9) == 0);
      if (rd_burst) it.read_final = (i == len - 1);
      else it.write_final = (i == len - 1);
      it.last_instruction      = $urandom_range(99) < 60;
      it.scheduler_in_data_out = $urandom_range(99) < 60;
      time_response(it);
      send_item(it);
    end
    repeat ($urandom_range(2)) begin
      it = random_item();
      it.read_enable  = 1'b0;
      it.write_enable = 1'b0;
      time_response(it);
      send_item(it);
    end
  endtask

  task automatic run_random(input int count);
    item_t it;
    int    target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 75) begin
        send_burst();
      end else begin
        it = random_item();
        if ($urandom_range(1)) time_response(it);
        send_item(it);
      end
    end
  endtask

  task automatic run_directed();
    // fields: rd, rd_final, wr, wr_final, last_ins, data_out, addr, wdata, resp_v, resp
    send_item(item_t'{0, 0, 0, 0, 0, 0, 32'h0, 64'h0, 0, 64'h0});
    // read with an unexpected response, top address
    send_item(item_t'{1, 0, 0, 0, 0, 0, '1, 64'h0, 1, '1});
    send_item(item_t'{1, 1, 0, 0, 0, 0, 32'h0, '1, 0, 64'h0});
    send_item(item_t'{1, 1, 0, 0, 1, 1, 32'h8000_0000, 64'h0, 0, 64'h0});
    // response word without valid must not reach the hold register
    send_item(item_t'{0, 0, 0, 0, 0, 0, 32'h0, 64'h0, 0, 64'h5555_aaaa_5555_aaaa});
    send_item(item_t'{0, 0, 1, 0, 0, 0, '1, '1, 1, 64'h0123_4567_89ab_cdef});
    send_item(item_t'{0, 0, 1, 0, 1, 1, 32'h0, 64'h0, 1, 64'h0});
    // last write of the last instruction in data-out
    send_item(item_t'{0, 0, 1, 1, 1, 1, 32'h1234_5678, 64'hdead_beef_f00d_cafe, 1, '1});
    send_item(item_t'{0, 0, 1, 1, 1, 0, 32'h0, '1, 1, 64'h0});
    // read and write together: read wins, write final still ends the wait
    send_item(item_t'{1, 0, 1, 1, 1, 1, 32'hffff_0000, '1, 1, 64'h0});
    send_item(item_t'{1, 0, 1, 1, 1, 1, 32'h0000_ffff, '1, 1, '1});
    send_item(item_t'{1, 1, 1, 1, 1, 1, '1, '1, 1, '1});
    send_item(item_t'{0, 1, 0, 1, 1, 1, '1, '1, 1, '1});
    send_item(item_t'{0, 0, 0, 0, 0, 0, 32'h0, 64'h0, 1, 64'h0});
    send_item(item_t'{0, 0, 0, 0, 0, 0, 32'h0, 64'h0, 0, 64'h0});
    send_item(item_t'{0, 0, 0, 0, 0, 0, 32'h0, 64'h0, 0, 64'h0});
  endtask

  initial begin : stimulus
    shadow                = new();
    cycles                = 0;
    sender_quiet          = 1'b0;
    receiver_quiet        = 1'b0;
    hold_request          = 1'b0;
    req_history           = '0;
    items_sent            = 0;
    rst                   = 1'b1;
    cfg_valid             = 1'b0;
    cfg_data              = 1'b0;
    item_valid            = 1'b0;
    read_enable           = 1'b0;
    read_final            = 1'b0;
    write_enable          = 1'b0;
    write_final           = 1'b0;
    last_instruction      = 1'b0;
    scheduler_in_data_out = 1'b0;
    req_address           = '0;
    req_write_data        = '0;
    response_valid        = 1'b0;
    response_word         = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_strict(1'b1);
    run_directed();
    run_random(60);

    // receiver holds off while the sender keeps offering beats
    hold_request = 1'b1;
    sender_quiet = 1'b1;
    run_random(20);

    // stretch with no idling on either side
    receiver_quiet = 1'b1;
    run_random(60);
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;

    write_strict(1'b0);
    run_random(100);

    write_strict(1'b1);
    run_random(70);
    wait_drained();
    run_random(80);

    wait_drained();
    if (shadow.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/msq_pkg.sv
rtl/msq_core.sv
rtl/msq_skid.sv
rtl/memory_request_sequencer.sv
dv/memory_request_sequencer_tb.sv
